/* rtl/text_stream_line_formatter_defines.svh */
// Assertion macros for the checker file of the line formatter.
`ifndef TEXT_STREAM_LINE_FORMATTER_DEFINES_SVH
`define TEXT_STREAM_LINE_FORMATTER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define TSLF_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TSLF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/tslf_pkg.sv */
// Types, character codes and helpers for the text stream line formatter.
package tslf_pkg;

    // Line counter is kept as six BCD digits and saturates at all nines.
    localparam int COUNT_DIGITS     = 6;
    localparam int NUMBER_WIDTH_DEF = 6;
    localparam int CFG_IDX_W        = 3;

    typedef logic [3:0]                 t_digit;
    typedef t_digit [COUNT_DIGITS-1:0]  t_bcd;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SQUEEZE_BLANK    = 3'd0,
        CFG_NUMBER_ALL       = 3'd1,
        CFG_NUMBER_NONBLANK  = 3'd2,
        CFG_SHOW_ENDS        = 3'd3,
        CFG_SHOW_TABS        = 3'd4,
        CFG_SHOW_NONPRINTING = 3'd5
    } t_cfg_idx;

    // Character codes.
    localparam logic [7:0] CH_TAB          = 8'd9;
    localparam logic [7:0] CH_NL           = 8'd10;
    localparam logic [7:0] CH_SPACE        = 8'd32;
    localparam logic [7:0] CH_DOLLAR       = 8'd36;
    localparam logic [7:0] CH_ZERO         = 8'd48;
    localparam logic [7:0] CH_QMARK        = 8'd63;
    localparam logic [7:0] CH_CARET        = 8'd94;
    localparam logic [7:0] CH_DEL          = 8'd127;
    localparam logic [7:0] CH_CTRL_LIMIT   = 8'd32;
    localparam logic [7:0] CH_CARET_OFFSET = 8'd64;

    // Saturating BCD increment of the line counter.
    function automatic t_bcd bcd_inc(input t_bcd v);
        t_bcd r;
        logic carry;
        logic all_nine;
        r        = v;
        carry    = 1'b1;
        all_nine = 1'b1;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            if (v[i] != 4'd9) begin
                all_nine = 1'b0;
            end
        end
        if (!all_nine) begin
            for (int i = 0; i < COUNT_DIGITS; i++) begin
                if (carry) begin
                    if (v[i] == 4'd9) begin
                        r[i] = 4'd0;
                    end else begin
                        r[i]  = v[i] + 4'd1;
                        carry = 1'b0;
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

/* rtl/text_stream_line_formatter.sv */
// Top level of the text stream line formatter: cat-style output filter.
// Each accepted input word yields zero to several output words. A plain byte
// passes through the job register and the output register at one word per cycle
// while the output is not stalled. A byte that expands (line number prefix, end
// marker, caret notation) holds the input side until its last word moves on, up
// to NUMBER_WIDTH+3 words when NUMBER_WIDTH >= 6, since the single output register
// drains one word per cycle when not stalled. A squeezed newline emits nothing.
// The line number is a six-digit BCD counter that stops at 999999.
module text_stream_line_formatter import tslf_pkg::*; #(
    parameter int NUMBER_WIDTH = NUMBER_WIDTH_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Input byte stream
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [7:0]           i_in_byte,
    // Output byte stream
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic [7:0]           o_out_byte,
    output logic                 o_last,
    // Configuration writes
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic                 i_cfg_data
);

    localparam int PLEN_MAX  = ((NUMBER_WIDTH > COUNT_DIGITS) ? NUMBER_WIDTH
                                                              : COUNT_DIGITS) + 1;
    localparam int PW        = $clog2(PLEN_MAX + 1);
    localparam int DW        = $clog2(COUNT_DIGITS + 1);
    localparam int DIW       = $clog2(COUNT_DIGITS);
    localparam logic [PW-1:0] NW_P = PW'(NUMBER_WIDTH);

    // Configuration registers
    logic r_squeeze, r_num_all, r_num_nonblank, r_show_ends, r_show_tabs, r_show_np;

    // Stream history and line counter
    logic r_prev_nl, r_prev_prev_nl;
    t_bcd r_count, n_count;

    // Job register: the run of words for one accepted input byte
    logic          r_job_valid, n_job_valid;
    logic          r_job_pre, n_job_pre;
    logic [PW-1:0] r_job_pos, n_job_pos;
    t_bcd          r_job_bcd, n_job_bcd;
    logic          r_job_dollar, n_job_dollar;
    logic          r_job_caret, n_job_caret;
    logic [7:0]    r_job_byte, n_job_byte;

    // Output register
    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_out_last;

    logic          is_nl, squeezed, numbered, in_acc, out_free, job_move, job_last;
    logic          pre_left, acc_caret;
    logic [7:0]    acc_byte, job_char, pre_char;
    logic [DW-1:0] nd;
    logic [PW-1:0] nd_ext, plen, lead, didx;
    t_bcd          inc_count;

    // Decode of the input byte against the stream history
    always_comb begin
        is_nl     = (i_in_byte == CH_NL);
        squeezed  = r_squeeze && r_prev_prev_nl && r_prev_nl && is_nl;
        numbered  = ((r_num_all && !r_num_nonblank) || (r_num_nonblank && !is_nl))
                    && r_prev_nl && !squeezed;
        inc_count = bcd_inc(r_count);
        n_count   = numbered ? inc_count : r_count;
    end

    // Tab and control byte rewriting into caret notation
    always_comb begin
        acc_byte  = i_in_byte;
        acc_caret = 1'b0;
        if (r_show_tabs && i_in_byte == CH_TAB) begin
            acc_caret = 1'b1;
            acc_byte  = CH_TAB + CH_CARET_OFFSET;
        end else if (r_show_np) begin
            if (i_in_byte < CH_CTRL_LIMIT && i_in_byte != CH_TAB && !is_nl) begin
                acc_caret = 1'b1;
                acc_byte  = i_in_byte + CH_CARET_OFFSET;
            end else if (i_in_byte == CH_DEL) begin
                acc_caret = 1'b1;
                acc_byte  = CH_QMARK;
            end
        end
    end

    // Prefix geometry: digit count, field length and the current prefix word
    always_comb begin
        nd = DW'(1);
        for (int i = 1; i < COUNT_DIGITS; i++) begin
            if (r_job_bcd[i] != 4'd0) begin
                nd = DW'(i + 1);
            end
        end
        nd_ext   = PW'(nd);
        plen     = ((nd_ext > NW_P) ? nd_ext : NW_P) + PW'(1);
        lead     = plen - PW'(1) - nd_ext;
        didx     = plen - PW'(2) - r_job_pos;
        pre_left = r_job_pre && (r_job_pos < plen);
        if (r_job_pos == plen - PW'(1)) begin
            pre_char = CH_TAB;
        end else if (r_job_pos < lead || didx >= PW'(COUNT_DIGITS)) begin
            pre_char = CH_SPACE;
        end else begin
            pre_char = CH_ZERO + {4'd0, r_job_bcd[didx[DIW-1:0]]};
        end
    end

    // Word selection and handshake
    always_comb begin
        job_last = !pre_left && !r_job_dollar && !r_job_caret;
        if (pre_left) begin
            job_char = pre_char;
        end else if (r_job_dollar) begin
            job_char = CH_DOLLAR;
        end else if (r_job_caret) begin
            job_char = CH_CARET;
        end else begin
            job_char = r_job_byte;
        end
        out_free   = !r_out_valid || i_out_ready;
        job_move   = r_job_valid && out_free;
        o_in_ready = !r_job_valid || (job_move && job_last);
        in_acc     = i_in_valid && o_in_ready;
    end

    // Next job: step through the run, then load a new byte if one is taken
    always_comb begin
        n_job_valid  = r_job_valid;
        n_job_pre    = r_job_pre;
        n_job_pos    = r_job_pos;
        n_job_bcd    = r_job_bcd;
        n_job_dollar = r_job_dollar;
        n_job_caret  = r_job_caret;
        n_job_byte   = r_job_byte;
        if (job_move) begin
            if (job_last) begin
                n_job_valid = 1'b0;
            end else if (pre_left) begin
                n_job_pos = r_job_pos + PW'(1);
            end else if (r_job_dollar) begin
                n_job_dollar = 1'b0;
            end else begin
                n_job_caret = 1'b0;
            end
        end
        if (in_acc && !squeezed) begin
            n_job_valid  = 1'b1;
            n_job_pre    = numbered;
            n_job_pos    = '0;
            n_job_bcd    = inc_count;
            n_job_dollar = r_show_ends && is_nl;
            n_job_caret  = acc_caret;
            n_job_byte   = acc_byte;
        end
    end

    // Control state, configuration and history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_squeeze      <= 1'b0;
            r_num_all      <= 1'b0;
            r_num_nonblank <= 1'b0;
            r_show_ends    <= 1'b0;
            r_show_tabs    <= 1'b0;
            r_show_np      <= 1'b0;
            r_prev_nl      <= 1'b1;
            r_prev_prev_nl <= 1'b1;
            r_count        <= '0;
            r_job_valid    <= 1'b0;
            r_job_pre      <= 1'b0;
            r_job_pos      <= '0;
            r_job_dollar   <= 1'b0;
            r_job_caret    <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_idx))
                    CFG_SQUEEZE_BLANK:    r_squeeze      <= i_cfg_data;
                    CFG_NUMBER_ALL:       r_num_all      <= i_cfg_data;
                    CFG_NUMBER_NONBLANK:  r_num_nonblank <= i_cfg_data;
                    CFG_SHOW_ENDS:        r_show_ends    <= i_cfg_data;
                    CFG_SHOW_TABS:        r_show_tabs    <= i_cfg_data;
                    CFG_SHOW_NONPRINTING: r_show_np      <= i_cfg_data;
                    default: ;
                endcase
            end
            if (in_acc) begin
                r_prev_prev_nl <= r_prev_nl;
                r_prev_nl      <= is_nl;
                r_count        <= n_count;
            end
            r_job_valid  <= n_job_valid;
            r_job_pre    <= n_job_pre;
            r_job_pos    <= n_job_pos;
            r_job_dollar <= n_job_dollar;
            r_job_caret  <= n_job_caret;
            if (out_free) begin
                r_out_valid <= r_job_valid;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_job_bcd  <= n_job_bcd;
        r_job_byte <= n_job_byte;
        if (out_free) begin
            r_out_byte <= job_char;
            r_out_last <= job_last;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_last      = r_out_last;

endmodule

/* rtl/tslf_checker.sv */
// Port-level checker for the text stream line formatter, with its bind.
`include "text_stream_line_formatter_defines.svh"

module tslf_checker import tslf_pkg::*; (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [7:0] o_out_byte,
    input logic       o_last
);

    // A stalled output word holds.
    `TSLF_ASSERT_NEXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_byte) && $stable(o_last), "output word changed while stalled")

    // A run never has a gap once its first word is out.
    `TSLF_ASSERT_NEXT(a_run_gapless, o_out_valid && i_out_ready && !o_last, o_out_valid, "gap inside an output run")

    // An end marker is followed by the newline that closes the run.
    `TSLF_ASSERT_NEXT(a_dollar_nl, o_out_valid && i_out_ready && !o_last && o_out_byte == CH_DOLLAR, o_out_byte == CH_NL && o_last, "end marker not followed by newline")

    // A caret is followed by the final word of its run.
    `TSLF_ASSERT_NEXT(a_caret_last, o_out_valid && i_out_ready && !o_last && o_out_byte == CH_CARET, o_last, "caret not followed by final word")

    // A newline always closes its run.
    `TSLF_ASSERT_SAME(a_nl_last, o_out_valid && o_out_byte == CH_NL, o_last, "newline not marked last")

endmodule

bind text_stream_line_formatter tslf_checker u_tslf_checker (.*);
